FILE: design/cns_pkg.sv
// Shared types and constants for the conditional nesting stack.
// Used by every module of the block but the RAM, and by the port checker.
package cns_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 16;
  localparam int unsigned MISSING_SAT   = 15;
  localparam int unsigned DEPTH_SAT     = 31;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    CMD_IF     = 3'd0,
    CMD_IFDEF  = 3'd1,
    CMD_IFNDEF = 3'd2,
    CMD_ELSE   = 3'd3,
    CMD_ELIF   = 3'd4,
    CMD_ENDIF  = 3'd5,
    CMD_EOF    = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ELSE_ELSE = 3'd1,
    ST_ELIF_ELSE = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_BAD_ARG   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_MISSING   = 3'd6
  } status_t;

  // one region entry, stored as {else_seen, done, active}
  typedef struct packed {
    logic else_seen;
    logic done;
    logic active;
  } entry_t;

  localparam entry_t ENTRY_BASE = '{else_seen: 1'b0, done: 1'b0, active: 1'b1};

  // result item, packed as it leaves on out_tdata (lowest field last here)
  typedef struct packed {
    logic [4:0] nesting_depth;
    logic [3:0] missing_endifs;
    status_t    status;
    logic       active;
  } res_t;

endpackage

FILE: design/cns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cns_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/cns_stack.sv
// Region stack: top and second entries in registers, deeper entries in RAM.
// Depends on cns_pkg and cns_ram.
module cns_stack #(
  parameter int unsigned MAX_DEPTH = cns_pkg::MAX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_fire,
  input  cns_pkg::cmd_t cmd,
  input  logic          condition,
  input  logic          argument_valid,
  output cns_pkg::res_t res
);
  import cns_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAX_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  entry_t        top_r, top_nxt;
  entry_t        second_r, second_nxt, second_cur;
  logic          sec_ram_r, sec_ram_nxt;

  logic          wr_en, rd_en;
  logic [2:0]    ram_rdata;
  entry_t        push_entry, upd;
  logic          push_req, push_cond;
  logic [CW-1:0] open_cnt;
  status_t       status;
  logic [3:0]    missing;

  cns_ram #(
    .WIDTH (3),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r - CW'(2))),
    .wr_data (second_cur),
    .rd_en   (rd_en),
    .rd_addr (AW'(count_r - CW'(3))),
    .rd_data (ram_rdata)
  );

  // after a pop the entry below the new top arrives from the RAM's registered read in the next cycle
  assign second_cur = sec_ram_r ? entry_t'(ram_rdata) : second_r;
  assign open_cnt   = count_r - CW'(1);

  always_comb begin
    count_nxt   = count_r;
    top_nxt     = top_r;
    second_nxt  = second_cur;
    sec_ram_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    status      = ST_OK;
    missing     = 4'd0;
    push_req    = 1'b0;
    push_cond   = condition;
    push_entry  = '0;
    upd         = top_r;
    if (req_fire) begin
      case (cmd)
        CMD_IF: begin
          push_req = 1'b1;
        end
        CMD_IFDEF, CMD_IFNDEF: begin
          if (!argument_valid) begin
            status = ST_BAD_ARG;
          end else begin
            push_req  = 1'b1;
            push_cond = (cmd == CMD_IFDEF) ? condition : !condition;
          end
        end
        CMD_ELSE: begin
          if (top_r.else_seen) status = ST_ELSE_ELSE;
          if (top_r.done) begin
            upd.active = 1'b0;
          end else begin
            upd.active = 1'b1;
            upd.done   = 1'b1;
          end
          upd.else_seen = 1'b1;
          top_nxt = upd;
        end
        CMD_ELIF: begin
          if (top_r.else_seen) status = ST_ELIF_ELSE;
          if (top_r.done || !condition) begin
            upd.active = 1'b0;
          end else begin
            upd.active = 1'b1;
            upd.done   = 1'b1;
          end
          top_nxt = upd;
        end
        CMD_ENDIF: begin
          if (count_r <= CW'(1)) begin
            status = ST_UNMATCHED;
          end else begin
            count_nxt = open_cnt;
            top_nxt   = second_cur;
            if (count_r >= CW'(3)) begin
              rd_en       = 1'b1;
              sec_ram_nxt = 1'b1;
            end
          end
        end
        CMD_EOF: begin
          missing   = (int'(open_cnt) > int'(MISSING_SAT)) ? 4'(MISSING_SAT) : 4'(open_cnt);
          if (open_cnt != '0) status = ST_MISSING;
          count_nxt = CW'(1);
          top_nxt   = ENTRY_BASE;
        end
        default: begin
        end
      endcase
      if (push_req) begin
        if (count_r >= CW'(MAX_DEPTH)) begin
          status = ST_OVERFLOW;
        end else begin
          // inside an inactive region the new region can never be taken
          push_entry.active = top_r.active && push_cond;
          push_entry.done   = !top_r.active || push_cond;
          top_nxt    = push_entry;
          second_nxt = top_r;
          count_nxt  = count_r + CW'(1);
          wr_en      = (count_r >= CW'(2));
        end
      end
    end
  end

  always_comb begin
    res.active         = top_nxt.active;
    res.status         = status;
    res.missing_endifs = missing;
    res.nesting_depth  = (int'(count_nxt) > int'(DEPTH_SAT)) ? 5'(DEPTH_SAT) : 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CW'(1);
      top_r     <= ENTRY_BASE;
      sec_ram_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      top_r     <= top_nxt;
      sec_ram_r <= sec_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    second_r <= second_nxt;
  end

endmodule

FILE: design/cns_outbuf.sv
// Two-slot result buffer: output register plus skid slot.
// Depends on cns_pkg.
module cns_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cns_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output cns_pkg::res_t out_data
);
  import cns_pkg::*;

  logic head_vld_r, head_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || out_ready) begin
      // head free: oldest waiting result moves up
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_nxt     = push_data;
        skid_vld_nxt = push;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = push;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

endmodule

FILE: design/conditional_nesting_stack.sv
// Top level of the conditional nesting stack.
// Depends on cns_pkg, cns_stack and cns_outbuf.
//
//  Channel | Dir | Payload
//  in_     | in  | directive: cmd, condition, argument_valid
//  out_    | out | active, status, missing_endifs, nesting_depth
//
// One directive per cycle while in_tready is high; its result is registered in the result
// buffer before it shows on out_. The stack top and count update as the directive is taken;
// deeper entries sit in a RAM whose registered read is issued by the pop itself.
// Reset gives a single active base entry and no waiting result.
// A two-slot result buffer keeps in_tready high while one result waits; it
// drops only when two results are held.
module conditional_nesting_stack #(
  parameter int unsigned MAX_DEPTH = cns_pkg::MAX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] cmd, [3] condition, [4] argument_valid, [7:5] zero
  input  logic [cns_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] active, [3:1] status, [7:4] missing_endifs, [12:8] nesting_depth, [15:13] zero
  output logic [cns_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import cns_pkg::*;

  logic in_fire;
  res_t res, out_res;

  assign in_fire = in_tvalid && in_tready;

  cns_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_fire       (in_fire),
    .cmd            (cmd_t'(in_tdata[2:0])),
    .condition      (in_tdata[3]),
    .argument_valid (in_tdata[4]),
    .res            (res)
  );

  cns_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .space     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {3'b000, out_res};

endmodule

FILE: design/cns_checker.sv
// Port-level checks for the conditional nesting stack, bound to the top level.
// Depends on cns_pkg.
module cns_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cns_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cns_pkg::*;

  // nothing waits on the output right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // an empty result buffer always takes a request
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result waiting");

  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:8] != 5'd0)
    else $error("base entry lost");

  a_missing_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[3:1] == ST_MISSING) == (out_tdata[7:4] != 4'd0)))
    else $error("missing endif count and status disagree");

endmodule

bind conditional_nesting_stack cns_checker u_cns_checker (.*);
